/* src/lrusd_pkg.sv */
package lrusd_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int USER_COUNT_DEF  = 4;

  localparam int BLOCK_W     = 32;
  localparam int USER_W      = 2;
  localparam int DEPTH_OUT_W = 6;
  localparam int COUNT_W     = 32;
  // depth + bin + hit total + miss total + evicted + evicted block, padded to bytes
  localparam int OUT_DATA_W  = 136;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_HIST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic load;
    logic start;
    logic scan;
    logic hist;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_end;
    logic scan_match;
    logic out_free;
  } sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

  // Fold a user code back into the implemented range
  function automatic logic [USER_W-1:0] user_wrap(input logic [USER_W-1:0] u, input int n);
    logic [USER_W-1:0] v;
    v = u;
    for (int i = 0; i < (1 << USER_W) - 1; i++) begin
      if (int'(v) >= n) v = v - USER_W'(n);
    end
    return v;
  endfunction

endpackage

/* src/lrusd_ctrl.sv */
module lrusd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrusd_pkg::sts_t sts,
  output lrusd_pkg::cmd_t cmd
);
  import lrusd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_START;
      ST_START: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_end) state_nxt = ST_DONE;
        else if (sts.scan_match) state_nxt = ST_HIST;
      end
      ST_HIST:  state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD:  cmd.load = 1'b1;
      ST_START: cmd.start = 1'b1;
      ST_SCAN:  cmd.scan = 1'b1;
      ST_HIST:  cmd.hist = 1'b1;
      ST_DONE:  cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

/* src/lrusd_dp.sv */
module lrusd_dp #(
  parameter int STACK_DEPTH = lrusd_pkg::STACK_DEPTH_DEF,
  parameter int USER_COUNT  = lrusd_pkg::USER_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrusd_pkg::cmd_t                   cmd,
  output lrusd_pkg::sts_t                   sts,
  input  logic [lrusd_pkg::BLOCK_W-1:0]     in_block,
  input  logic [lrusd_pkg::USER_W-1:0]      in_user,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [lrusd_pkg::OUT_DATA_W-1:0]  out_data
);
  import lrusd_pkg::*;

  localparam int TOTAL = USER_COUNT * STACK_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int UW    = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int PAD_W = OUT_DATA_W - (DEPTH_OUT_W + 3 * COUNT_W + 1 + BLOCK_W);

  logic [BLOCK_W-1:0] stk_mem  [TOTAL];
  logic [COUNT_W-1:0] hist_mem [TOTAL];
  logic [COUNT_W-1:0] hcnt_mem [USER_COUNT];
  logic [COUNT_W-1:0] mcnt_mem [USER_COUNT];
  logic [DW-1:0]      occ_mem  [USER_COUNT];

  logic [BLOCK_W-1:0] stk_rd_r;
  logic [COUNT_W-1:0] hist_rd_r, hcnt_rd_r, mcnt_rd_r;
  logic [DW-1:0]      occ_rd_r;

  logic [AW-1:0]      clr_idx_r;
  logic               out_valid_r;
  logic [BLOCK_W-1:0] blk_r, carry_r, evb_r;
  logic [UW-1:0]      user_r;
  logic [AW-1:0]      base_r;
  logic [DW-1:0]      d_r, occ_r;
  logic               hit_r, ev_r;
  logic [COUNT_W-1:0] bin_r;
  logic               out_hit_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               scan_end, scan_match, full, usr_clr;
  logic [DW-1:0]      d_inc;
  logic [AW-1:0]      cur_addr, nxt_addr;
  logic               stk_we, stk_re;
  logic [AW-1:0]      stk_raddr;
  logic               hist_we, hist_re;
  logic [AW-1:0]      hist_waddr;
  logic [COUNT_W-1:0] hist_wdata, bin_nxt;
  logic [UW-1:0]      cnt_waddr;
  logic               hcnt_we, mcnt_we, occ_we;
  logic [COUNT_W-1:0] hcnt_nxt, mcnt_nxt, hcnt_wdata, mcnt_wdata;
  logic [DW-1:0]      occ_wdata;
  logic [COUNT_W-1:0] hit_total, miss_total;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_comb begin
    full       = (occ_r == DW'(STACK_DEPTH));
    scan_end   = (d_r == occ_r);
    scan_match = !scan_end && (stk_rd_r == blk_r);
    d_inc      = d_r + DW'(1);
    cur_addr   = base_r + AW'(d_r);
    nxt_addr   = base_r + AW'(d_inc);

    // walk: each slot takes the entry above it, stop where the block sat
    stk_we    = cmd.scan && (!scan_end || !full);
    stk_re    = cmd.start || (cmd.scan && !scan_end && !scan_match && (d_inc < occ_r));
    stk_raddr = cmd.start ? base_r : nxt_addr;

    bin_nxt    = sat_inc(hist_rd_r);
    hist_re    = cmd.scan && scan_match;
    hist_we    = cmd.clear || cmd.hist;
    hist_waddr = cmd.clear ? clr_idx_r : cur_addr;
    hist_wdata = cmd.clear ? '0 : bin_nxt;

    usr_clr    = cmd.clear && (int'(clr_idx_r) < USER_COUNT);
    cnt_waddr  = cmd.clear ? UW'(clr_idx_r) : user_r;
    hcnt_nxt   = sat_inc(hcnt_rd_r);
    mcnt_nxt   = sat_inc(mcnt_rd_r);
    hcnt_we    = usr_clr || (cmd.finish && hit_r);
    mcnt_we    = usr_clr || (cmd.finish && !hit_r);
    hcnt_wdata = cmd.clear ? '0 : hcnt_nxt;
    mcnt_wdata = cmd.clear ? '0 : mcnt_nxt;
    occ_we     = usr_clr || (cmd.finish && !hit_r && !full);
    occ_wdata  = cmd.clear ? '0 : occ_r + DW'(1);

    hit_total  = hit_r ? hcnt_nxt : hcnt_rd_r;
    miss_total = hit_r ? mcnt_rd_r : mcnt_nxt;
    out_data_nxt = {{PAD_W{1'b0}}, evb_r, ev_r, miss_total, hit_total,
                    (hit_r ? bin_r : {COUNT_W{1'b0}}),
                    (hit_r ? DEPTH_OUT_W'(d_r) : {DEPTH_OUT_W{1'b0}})};
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[cur_addr] <= carry_r;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rd_r <= hist_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (hcnt_we) hcnt_mem[cnt_waddr] <= hcnt_wdata;
    if (mcnt_we) mcnt_mem[cnt_waddr] <= mcnt_wdata;
    if (occ_we)  occ_mem[cnt_waddr]  <= occ_wdata;
    if (cmd.load) begin
      hcnt_rd_r <= hcnt_mem[user_r];
      mcnt_rd_r <= mcnt_mem[user_r];
      occ_rd_r  <= occ_mem[user_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_idx_r <= clr_idx_r + AW'(1);
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk_r  <= in_block;
      user_r <= UW'(user_wrap(in_user, USER_COUNT));
    end
    if (cmd.load) base_r <= AW'(user_r * STACK_DEPTH);
    if (cmd.start) begin
      occ_r   <= occ_rd_r;
      d_r     <= '0;
      carry_r <= blk_r;
      hit_r   <= 1'b0;
      ev_r    <= 1'b0;
      evb_r   <= '0;
    end
    if (cmd.scan) begin
      if (scan_end) begin
        if (full) begin
          ev_r  <= 1'b1;
          evb_r <= carry_r;
        end
      end else if (scan_match) begin
        hit_r <= 1'b1;
      end else begin
        carry_r <= stk_rd_r;
        d_r     <= d_inc;
      end
    end
    if (cmd.hist) bin_r <= bin_nxt;
    if (cmd.finish) begin
      out_hit_r  <= hit_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.clr_last   = (clr_idx_r == AW'(TOTAL - 1));
  assign sts.scan_end   = scan_end;
  assign sts.scan_match = scan_match;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_data  = out_data_r;

endmodule

/* src/lru_stack_reuse_distance_top.sv */
// Flow: one item in flight at a time; a miss walks the whole occupied stack, a hit
//   walks to its depth and then updates its histogram bin before the result.
// The walk over the stack memory moves one entry per cycle; a new item is taken
//   only after the last result has been handed to a free output register.
// Reset: synchronous; a clearing pass over all USER_COUNT * STACK_DEPTH entries zeroes
//   histograms, counters and occupancies, in_tready stays low until it ends.
module lru_stack_reuse_distance_top #(
  parameter int STACK_DEPTH = lrusd_pkg::STACK_DEPTH_DEF,
  parameter int USER_COUNT  = lrusd_pkg::USER_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] block_number
  input  logic [1:0]   in_tuser,   // [1:0] user_id
  output logic         out_tvalid,
  input  logic         out_tready,
  // [5:0] stack_depth, [37:6] bin_count, [69:38] hit_total,
  // [101:70] miss_total, [102] evicted, [134:103] evicted_block, [135] zero
  output logic [135:0] out_tdata,
  output logic [0:0]   out_tuser   // [0] hit
);
  import lrusd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lrusd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrusd_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .USER_COUNT  (USER_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_block  (in_tdata),
    .in_user   (in_tuser),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_hit   (out_tuser[0]),
    .out_data  (out_tdata)
  );

`ifndef SYNTHESIS
  // busy from the cycle after a transfer in
  assert property (@(posedge clk) disable iff (!rst_n) cmd.accept |=> !in_tready)
    else $error("input taken while an item is in progress");

  assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> sts.out_free)
    else $error("result overwrote one still waiting");

  assert property (@(posedge clk) disable iff (!rst_n) cmd.clear |-> !in_tready)
    else $error("input offered during clearing pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tdata[102] && (out_tdata[37:6] != 32'd0)))
    else $error("hit result with eviction or empty bin");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lrusd_pkg::*;

  localparam int USERS = USER_COUNT_DEF;
  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int POOL  = 96;

  typedef struct packed {
    logic                   hit;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [COUNT_W-1:0]     bin;
    logic [COUNT_W-1:0]     hits;
    logic [COUNT_W-1:0]     misses;
    logic                   ev;
    logic [BLOCK_W-1:0]     ev_blk;
  } access_result_t;

  typedef struct {
    logic [BLOCK_W-1:0] blk;
    logic [USER_W-1:0]  uid;
    bit                 typed;
    access_result_t     res;
  } probe_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BLOCK_W-1:0]    in_tdata;
  logic [USER_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  // Shadow of the per-user stacks, histograms and counters
  logic [BLOCK_W-1:0] stack_blk [USERS][DEPTH];
  int                 occupancy [USERS];
  logic [COUNT_W-1:0] hist_bin  [USERS][DEPTH];
  logic [COUNT_W-1:0] hit_cnt   [USERS];
  logic [COUNT_W-1:0] miss_cnt  [USERS];

  access_result_t pending_results[$];
  probe_t         directed_probes[$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int accesses_sent;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int deepest_hit;
  int errors;

  access_result_t want;
  access_result_t got;

  lru_stack_reuse_distance_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic access_result_t lru_access(logic [BLOCK_W-1:0] blk,
                                                logic [USER_W-1:0] uid);
    access_result_t r;
    int u;
    int d;
    int occ;
    bit found;
    r = '0;
    u = int'(uid) % USERS;
    occ = occupancy[u];
    found = 1'b0;
    d = 0;
    for (int i = 0; i < occ; i++) begin
      if (!found && stack_blk[u][i] == blk) begin
        found = 1'b1;
        d = i;
      end
    end
    if (found) begin
      hit_cnt[u] = (hit_cnt[u] == '1) ? hit_cnt[u] : hit_cnt[u] + 1'b1;
      hist_bin[u][d] = (hist_bin[u][d] == '1) ? hist_bin[u][d] : hist_bin[u][d] + 1'b1;
      r.hit = 1'b1;
      r.depth = DEPTH_OUT_W'(d);
      r.bin = hist_bin[u][d];
      for (int i = d; i > 0; i--) stack_blk[u][i] = stack_blk[u][i-1];
    end else begin
      miss_cnt[u] = (miss_cnt[u] == '1) ? miss_cnt[u] : miss_cnt[u] + 1'b1;
      // full stack: drop the LRU entry before the push
      if (occ == DEPTH) begin
        r.ev = 1'b1;
        r.ev_blk = stack_blk[u][occ-1];
        occ--;
      end
      for (int i = occ; i > 0; i--) stack_blk[u][i] = stack_blk[u][i-1];
      occ++;
    end
    stack_blk[u][0] = blk;
    occupancy[u] = occ;
    r.hits = hit_cnt[u];
    r.misses = miss_cnt[u];
    return r;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v)
      flag_error($sformatf("result %0d %s: expected 0x%08h, got 0x%08h",
                           results_seen, name, want_v, got_v));
  endfunction

  task automatic add_probe(logic [BLOCK_W-1:0] blk, logic [USER_W-1:0] uid, bit typed,
                           logic hit, int depth, int bin, int hits, int misses);
    probe_t p;
    p.blk = blk;
    p.uid = uid;
    p.typed = typed;
    p.res = '0;
    p.res.hit = hit;
    p.res.depth = DEPTH_OUT_W'(depth);
    p.res.bin = COUNT_W'(bin);
    p.res.hits = COUNT_W'(hits);
    p.res.misses = COUNT_W'(misses);
    directed_probes.push_back(p);
  endtask

  // Enter and leave at a falling edge; in_tvalid is left high after the transfer
  task automatic send_access(logic [BLOCK_W-1:0] blk, logic [USER_W-1:0] uid, bit typed,
                             access_result_t typed_res);
    access_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tuser  <= uid;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = lru_access(blk, uid);
    pending_results.push_back(typed ? typed_res : predicted);
    accesses_sent++;
    @(negedge clk);
  endtask

  // Receiver: random back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.hit    = out_tuser[0];
      got.depth  = out_tdata[5:0];
      got.bin    = out_tdata[37:6];
      got.hits   = out_tdata[69:38];
      got.misses = out_tdata[101:70];
      got.ev     = out_tdata[102];
      got.ev_blk = out_tdata[134:103];
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result, data 0x%h hit %0b", out_tdata, out_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(got.hit));
        check_field("stack_depth", 32'(want.depth), 32'(got.depth));
        check_field("bin_count", want.bin, got.bin);
        check_field("hit_total", want.hits, got.hits);
        check_field("miss_total", want.misses, got.misses);
        check_field("evicted", 32'(want.ev), 32'(got.ev));
        check_field("evicted_block", want.ev_blk, got.ev_blk);
        if (want.hit) begin
          hits_seen++;
          if (int'(want.depth) > deepest_hit) deepest_hit = int'(want.depth);
        end
        if (want.ev) evictions_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    logic [BLOCK_W-1:0] pool [USERS][POOL];
    logic [BLOCK_W-1:0] blk;
    logic [USER_W-1:0]  uid;
    int kind;
    int burst;
    int span;
    int sweep_u;
    int k;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    errors = 0;
    accesses_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    evictions_seen = 0;
    deepest_hit = 0;
    sender_idle_pct = 12;
    receiver_idle_pct = 83;
    for (int u = 0; u < USERS; u++) begin
      occupancy[u] = 0;
      hit_cnt[u] = '0;
      miss_cnt[u] = '0;
      for (int i = 0; i < DEPTH; i++) begin
        stack_blk[u][i] = '0;
        hist_bin[u][i] = '0;
      end
      for (int i = 0; i < POOL; i++) pool[u][i] = $urandom();
    end

    //        block         user typed hit depth bin hits misses
    add_probe(32'h0000_0000, 0, 1, 0, 0, 0, 0, 1);
    add_probe(32'hFFFF_FFFF, 3, 1, 0, 0, 0, 0, 1);
    add_probe(32'hFFFF_FFFF, 3, 1, 1, 0, 1, 1, 1);   // hit at MRU, stack unchanged
    add_probe(32'h0000_0000, 0, 1, 1, 0, 1, 1, 1);
    add_probe(32'h0000_0000, 1, 1, 0, 0, 0, 0, 1);   // stacks are per user
    add_probe(32'hFFFF_FFFF, 2, 1, 0, 0, 0, 0, 1);
    add_probe(32'h0000_0001, 0, 1, 0, 0, 0, 1, 2);
    add_probe(32'h8000_0000, 0, 1, 0, 0, 0, 1, 3);
    add_probe(32'hAAAA_AAAA, 0, 1, 0, 0, 0, 1, 4);
    add_probe(32'h0000_0000, 0, 1, 1, 3, 1, 2, 4);
    add_probe(32'hFFFF_FFFF, 3, 1, 1, 0, 2, 2, 1);
    add_probe(32'h5555_5555, 0, 0, 0, 0, 0, 0, 0);
    add_probe(32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
    add_probe(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_probe(32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
    add_probe(32'hFFFF_FFFE, 3, 0, 0, 0, 0, 0, 0);
    add_probe(32'hFFFF_FFFF, 3, 0, 0, 0, 0, 0, 0);
    add_probe(32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0);
    add_probe(32'h0000_0000, 1, 0, 0, 0, 0, 0, 0);
    add_probe(32'h0000_FFFF, 2, 0, 0, 0, 0, 0, 0);
    add_probe(32'hFFFF_0000, 2, 0, 0, 0, 0, 0, 0);
    add_probe(32'hFFFF_FFFF, 2, 0, 0, 0, 0, 0, 0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_probes[i])
      send_access(directed_probes[i].blk, directed_probes[i].uid,
                  directed_probes[i].typed, directed_probes[i].res);

    for (int phase = 1; phase <= 3; phase++) begin
      // hold the sender until the block has drained
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
      @(negedge clk);
      sender_idle_pct   = (phase == 1) ? 12 : (phase == 2) ? 83 : 0;
      receiver_idle_pct = (phase == 1) ? 83 : (phase == 2) ? 12 : 0;
      while (accesses_sent < phase * 600) begin
        kind = $urandom_range(99);
        burst = $urandom_range(20, 80);
        span = $urandom_range(8, POOL);
        sweep_u = $urandom_range(USERS - 1);
        // sweep widths 63..65 give hits near or at the deepest slot, or misses with eviction once the stack fills
        if (kind >= 60 && kind < 80) begin
          span = $urandom_range(DEPTH - 1, DEPTH + 1);
          burst = $urandom_range(2 * DEPTH, 3 * DEPTH);
        end
        for (k = 0; k < burst; k++) begin
          if (kind < 60) begin
            uid = USER_W'($urandom_range(USERS - 1));
            blk = pool[uid][$urandom_range(span - 1)];
          end else if (kind < 80) begin
            uid = USER_W'(sweep_u);
            blk = pool[uid][k % span];
          end else begin
            uid = USER_W'($urandom_range(USERS - 1));
            blk = $urandom();
          end
          send_access(blk, uid, 1'b0, '0);
        end
        repeat (4) pool[$urandom_range(USERS - 1)][$urandom_range(POOL - 1)] = $urandom();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    $display("Checked %0d accesses over 4 users: %0d hits (deepest at %0d), %0d misses,",
             results_seen, hits_seen, deepest_hit, results_seen - hits_seen);
    $display("%0d evictions, under three idle mixes on both sides", evictions_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
